// ===== hdl/emc_pkg.sv =====
package emc_pkg;

  // Default datapath width and fixed field widths
  localparam int WORD_BITS_DEF = 16;
  localparam int FIELD_W       = 16;
  localparam int CFG_IDX_W     = 2;

  // Register reset values
  localparam int RST_MODULUS   = 3571;
  localparam int RST_GENERATOR = 5;
  localparam int RST_PRIV_KEY  = 1;
  localparam int RST_EPH_KEY   = 7;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODULUS   = 2'd0,
    CFG_GENERATOR = 2'd1,
    CFG_PRIV_KEY  = 2'd2,
    CFG_EPH_KEY   = 2'd3
  } cfg_idx_e;

  // Multiplier operand selects
  typedef enum logic {
    A_ONE  = 1'b0,
    A_BASE = 1'b1
  } a_sel_e;

  typedef enum logic [2:0] {
    B_BASE = 3'd0,
    B_ACC  = 3'd1,
    B_GEN  = 3'd2,
    B_MSG  = 3'd3,
    B_C1   = 3'd4,
    B_C2   = 3'd5,
    B_PRIV = 3'd6
  } b_sel_e;

  // Register write-back sources
  typedef enum logic [1:0] {
    BASE_HOLD = 2'd0,
    BASE_MM   = 2'd1,
    BASE_TMP  = 2'd2
  } base_src_e;

  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_ONE  = 2'd1,
    ACC_MM   = 2'd2
  } acc_src_e;

  typedef enum logic [1:0] {
    RES_HOLD = 2'd0,
    RES_ZERO = 2'd1,
    RES_ACC  = 2'd2,
    RES_MM   = 2'd3
  } res_src_e;

  typedef enum logic [2:0] {
    EXP_HOLD     = 3'd0,
    EXP_SHIFT    = 3'd1,
    EXP_PRIV     = 3'd2,
    EXP_EPH      = 3'd3,
    EXP_NEG_PRIV = 3'd4,
    EXP_NEG_MM   = 3'd5
  } exp_src_e;

  // Controller to datapath command
  typedef struct packed {
    logic      load;
    logic      out_ld;
    logic      mm_start;
    a_sel_e    a_sel;
    b_sel_e    b_sel;
    logic      m_pm1;
    base_src_e base_src;
    acc_src_e  acc_src;
    logic      tmp_ld;
    res_src_e  res1_src;
    res_src_e  res2_src;
    exp_src_e  exp_src;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic mm_busy;
    logic mm_done;
    logic exp_zero;
    logic exp_lsb;
    logic exp_last;
    logic p_small;
    logic x_ge_p;
    logic dec;
  } stat_t;

endpackage

// ===== hdl/emc_mulmod.sv =====
module emc_mulmod import emc_pkg::*; #(
  parameter int W = WORD_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start_i,
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] m_i,
  output logic         busy_o,
  output logic         done_o,
  output logic [W-1:0] res_o
);

  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  a_q, b_q, m_q, acc_q, acc_d;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [W+1:0]  sum, dif1, dif2, m_ext, m2_ext;

  // One bit of b per cycle, MSB first: acc = 2*acc + bit*a, reduced below m
  assign m_ext  = {2'b00, m_q};
  assign m2_ext = {1'b0, m_q, 1'b0};
  assign sum    = {1'b0, acc_q, 1'b0} + (b_q[W-1] ? {2'b00, a_q} : '0);
  assign dif1   = sum - m_ext;
  assign dif2   = sum - m2_ext;

  always_comb begin
    if (sum >= m2_ext) begin
      acc_d = dif2[W-1:0];
    end else if (sum >= m_ext) begin
      acc_d = dif1[W-1:0];
    end else begin
      acc_d = sum[W-1:0];
    end
  end

  // Sequencing
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Operands and partial result
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      m_q   <= m_i;
      acc_q <= '0;
    end else if (busy_q) begin
      acc_q <= acc_d;
      b_q   <= {b_q[W-2:0], 1'b0};
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign res_o  = acc_q;

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> busy_q)
    else $error("mulmod not busy after start");

  a_last_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !start_i && cnt_q == CW'(1)) |=> (done_q && !busy_q))
    else $error("mulmod did not finish after last bit");

endmodule

// ===== hdl/emc_datapath.sv =====
module emc_datapath import emc_pkg::*; #(
  parameter int W = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [W-1:0]         cfg_data_i,
  input  logic                 req_type_i,
  input  logic [FIELD_W-1:0]   message_i,
  input  logic [FIELD_W-1:0]   cipher_first_i,
  input  logic [FIELD_W-1:0]   cipher_second_i,
  input  cmd_t                 cmd_i,
  output stat_t                stat_o,
  output logic                 was_decrypt_o,
  output logic [FIELD_W-1:0]   out_first_o,
  output logic [FIELD_W-1:0]   out_second_o
);

  logic [W-1:0] mod_q, gen_q, priv_q, eph_q;
  logic [W-1:0] msg_q, c1_q, c2_q;
  logic         dec_q;
  logic [W-1:0] base_q, acc_q, tmp_q, exp_q, res1_q, res2_q;
  logic [W-1:0] out1_q, out2_q;
  logic         out_dec_q;
  logic [W-1:0] mm_a, mm_b, mm_m, mm_res;
  logic         mm_busy, mm_done;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_q  <= W'(RST_MODULUS);
      gen_q  <= W'(RST_GENERATOR);
      priv_q <= W'(RST_PRIV_KEY);
      eph_q  <= W'(RST_EPH_KEY);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MODULUS:   mod_q  <= cfg_data_i;
        CFG_GENERATOR: gen_q  <= cfg_data_i;
        CFG_PRIV_KEY:  priv_q <= cfg_data_i;
        CFG_EPH_KEY:   eph_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Multiplier operand selection
  assign mm_a = (cmd_i.a_sel == A_BASE) ? base_q : W'(1);
  assign mm_m = cmd_i.m_pm1 ? (mod_q - W'(1)) : mod_q;

  always_comb begin
    unique case (cmd_i.b_sel)
      B_BASE:  mm_b = base_q;
      B_ACC:   mm_b = acc_q;
      B_GEN:   mm_b = gen_q;
      B_MSG:   mm_b = msg_q;
      B_C1:    mm_b = c1_q;
      B_C2:    mm_b = c2_q;
      B_PRIV:  mm_b = priv_q;
      default: mm_b = base_q;
    endcase
  end

  emc_mulmod #(.W(W)) u_mulmod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mm_start),
    .a_i     (mm_a),
    .b_i     (mm_b),
    .m_i     (mm_m),
    .busy_o  (mm_busy),
    .done_o  (mm_done),
    .res_o   (mm_res)
  );

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      dec_q <= req_type_i;
      msg_q <= W'(message_i);
      c1_q  <= W'(cipher_first_i);
      c2_q  <= W'(cipher_second_i);
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.base_src)
      BASE_MM:  base_q <= mm_res;
      BASE_TMP: base_q <= tmp_q;
      default:  ;
    endcase
    unique case (cmd_i.acc_src)
      ACC_ONE: acc_q <= W'(1);
      ACC_MM:  acc_q <= mm_res;
      default: ;
    endcase
    if (cmd_i.tmp_ld) begin
      tmp_q <= acc_q;
    end
    unique case (cmd_i.exp_src)
      EXP_SHIFT:    exp_q <= exp_q >> 1;
      EXP_PRIV:     exp_q <= priv_q;
      EXP_EPH:      exp_q <= eph_q;
      EXP_NEG_PRIV: exp_q <= mod_q - W'(1) - priv_q;
      EXP_NEG_MM:   exp_q <= mod_q - W'(1) - mm_res;
      default:      ;
    endcase
    unique case (cmd_i.res1_src)
      RES_ZERO: res1_q <= '0;
      RES_ACC:  res1_q <= acc_q;
      RES_MM:   res1_q <= mm_res;
      default:  ;
    endcase
    unique case (cmd_i.res2_src)
      RES_ZERO: res2_q <= '0;
      RES_ACC:  res2_q <= acc_q;
      RES_MM:   res2_q <= mm_res;
      default:  ;
    endcase
  end

  // Output beat register
  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      out_dec_q <= dec_q;
      out1_q    <= res1_q;
      out2_q    <= res2_q;
    end
  end

  assign was_decrypt_o = out_dec_q;
  assign out_first_o   = FIELD_W'(out1_q);
  assign out_second_o  = FIELD_W'(out2_q);

  // Status
  assign stat_o.mm_busy  = mm_busy;
  assign stat_o.mm_done  = mm_done;
  assign stat_o.exp_zero = (exp_q == '0);
  assign stat_o.exp_lsb  = exp_q[0];
  assign stat_o.exp_last = ((exp_q >> 1) == '0);
  assign stat_o.p_small  = (mod_q < W'(2));
  assign stat_o.x_ge_p   = (priv_q >= mod_q);
  assign stat_o.dec      = dec_q;

endmodule

// ===== hdl/emc_ctrl.sv =====
module emc_ctrl import emc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_CHECK  = 15'b000000000000010,
    S_XRED   = 15'b000000000000100,
    S_XRED_W = 15'b000000000001000,
    S_BRED   = 15'b000000000010000,
    S_BRED_W = 15'b000000000100000,
    S_POW    = 15'b000000001000000,
    S_MUL_W  = 15'b000000010000000,
    S_SQR    = 15'b000000100000000,
    S_SQR_W  = 15'b000001000000000,
    S_MRED   = 15'b000010000000000,
    S_MRED_W = 15'b000100000000000,
    S_FIN    = 15'b001000000000000,
    S_FIN_W  = 15'b010000000000000,
    S_OUT    = 15'b100000000000000
  } state_e;

  // Which exponentiation of an encrypt is running
  typedef enum logic [1:0] {
    PASS_PUB    = 2'd0,
    PASS_R      = 2'd1,
    PASS_SHARED = 2'd2
  } pass_e;

  state_e state_q, state_d;
  pass_e  pass_q, pass_d;
  logic   out_valid_q, out_valid_d;
  cmd_t   cmd;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd;

  // Sequencer
  always_comb begin
    state_d     = state_q;
    pass_d      = pass_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd         = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd.load = 1'b1;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat_i.p_small) begin
          cmd.res1_src = RES_ZERO;
          cmd.res2_src = RES_ZERO;
          state_d      = S_OUT;
        end else if (stat_i.dec) begin
          state_d = S_XRED;
        end else begin
          pass_d  = PASS_PUB;
          state_d = S_BRED;
        end
      end
      // decrypt exponent p-1-x, with x first reduced mod p-1 when x >= p
      S_XRED: begin
        if (stat_i.x_ge_p) begin
          cmd.mm_start = 1'b1;
          cmd.a_sel    = A_ONE;
          cmd.b_sel    = B_PRIV;
          cmd.m_pm1    = 1'b1;
          state_d      = S_XRED_W;
        end else begin
          cmd.exp_src = EXP_NEG_PRIV;
          state_d     = S_BRED;
        end
      end
      S_XRED_W: begin
        if (stat_i.mm_done) begin
          cmd.exp_src = EXP_NEG_MM;
          state_d     = S_BRED;
        end
      end
      // base reduced mod p, accumulator set to one
      S_BRED: begin
        cmd.mm_start = 1'b1;
        cmd.a_sel    = A_ONE;
        cmd.b_sel    = stat_i.dec ? B_C1 : B_GEN;
        state_d      = S_BRED_W;
      end
      S_BRED_W: begin
        if (stat_i.mm_done) begin
          cmd.base_src = BASE_MM;
          cmd.acc_src  = ACC_ONE;
          if (!stat_i.dec) begin
            cmd.exp_src = (pass_q == PASS_PUB) ? EXP_PRIV : EXP_EPH;
          end
          state_d = S_POW;
        end
      end
      // square-and-multiply, exponent LSB first
      S_POW: begin
        if (stat_i.exp_zero) begin
          if (stat_i.dec) begin
            state_d = S_MRED;
          end else begin
            unique case (pass_q)
              PASS_PUB: begin
                cmd.tmp_ld = 1'b1;
                pass_d     = PASS_R;
                state_d    = S_BRED;
              end
              PASS_R: begin
                cmd.res1_src = RES_ACC;
                cmd.base_src = BASE_TMP;
                cmd.acc_src  = ACC_ONE;
                cmd.exp_src  = EXP_EPH;
                pass_d       = PASS_SHARED;
                state_d      = S_POW;
              end
              default: begin
                state_d = S_MRED;
              end
            endcase
          end
        end else if (stat_i.exp_lsb) begin
          cmd.mm_start = 1'b1;
          cmd.a_sel    = A_BASE;
          cmd.b_sel    = B_ACC;
          state_d      = S_MUL_W;
        end else begin
          state_d = S_SQR;
        end
      end
      S_MUL_W: begin
        if (stat_i.mm_done) begin
          cmd.acc_src = ACC_MM;
          if (stat_i.exp_last) begin
            cmd.exp_src = EXP_SHIFT;
            state_d     = S_POW;
          end else begin
            state_d = S_SQR;
          end
        end
      end
      S_SQR: begin
        cmd.mm_start = 1'b1;
        cmd.a_sel    = A_BASE;
        cmd.b_sel    = B_BASE;
        state_d      = S_SQR_W;
      end
      S_SQR_W: begin
        if (stat_i.mm_done) begin
          cmd.base_src = BASE_MM;
          cmd.exp_src  = EXP_SHIFT;
          state_d      = S_POW;
        end
      end
      // plaintext or c2 reduced mod p, then the final product
      S_MRED: begin
        cmd.mm_start = 1'b1;
        cmd.a_sel    = A_ONE;
        cmd.b_sel    = stat_i.dec ? B_C2 : B_MSG;
        state_d      = S_MRED_W;
      end
      S_MRED_W: begin
        if (stat_i.mm_done) begin
          cmd.base_src = BASE_MM;
          state_d      = S_FIN;
        end
      end
      S_FIN: begin
        cmd.mm_start = 1'b1;
        cmd.a_sel    = A_BASE;
        cmd.b_sel    = B_ACC;
        state_d      = S_FIN_W;
      end
      S_FIN_W: begin
        if (stat_i.mm_done) begin
          if (stat_i.dec) begin
            cmd.res1_src = RES_MM;
            cmd.res2_src = RES_ZERO;
          end else begin
            cmd.res2_src = RES_MM;
          end
          state_d = S_OUT;
        end
      end
      // hand the result to the output register once it is free
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd.out_ld  = 1'b1;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pass_q      <= PASS_PUB;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pass_q      <= pass_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.mm_start |-> !stat_i.mm_busy)
    else $error("multiplier started while busy");

  a_done_waited: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat_i.mm_done |-> (state_q == S_XRED_W || state_q == S_BRED_W ||
                        state_q == S_MUL_W || state_q == S_SQR_W ||
                        state_q == S_MRED_W || state_q == S_FIN_W))
    else $error("multiplier result arrived outside a wait state");

  a_accept_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_CHECK))
    else $error("accepted beat did not start a request");

endmodule

// ===== hdl/elgamal_modexp_cipher.sv =====
// Work: each modular product runs in the bit-serial multiplier.
// Encrypt runs three reductions, three exponentiations (up to 2*WORD_BITS-1 products each)
// and a final product.
// Throughput: one request at a time; the next beat is taken once the result is in the
// output register, which may still be waiting on out_ready_i.
// Reset: rst_ni is asynchronous active low; configuration registers return to 3571, 5, 1 and 7.
module elgamal_modexp_cipher import emc_pkg::*; #(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [WORD_BITS-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 req_type_i,
  input  logic [FIELD_W-1:0]   message_i,
  input  logic [FIELD_W-1:0]   cipher_first_i,
  input  logic [FIELD_W-1:0]   cipher_second_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 was_decrypt_o,
  output logic [FIELD_W-1:0]   out_first_o,
  output logic [FIELD_W-1:0]   out_second_o
);

  cmd_t  cmd;
  stat_t stat;

  emc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  emc_datapath #(.W(WORD_BITS)) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .req_type_i      (req_type_i),
    .message_i       (message_i),
    .cipher_first_i  (cipher_first_i),
    .cipher_second_i (cipher_second_i),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .was_decrypt_o   (was_decrypt_o),
    .out_first_o     (out_first_o),
    .out_second_o    (out_second_o)
  );

endmodule
